[design/open_share_state_table_defines.svh]
// Assertion macros for the open share state table checker.
// No dependencies.
`ifndef OPEN_SHARE_STATE_TABLE_DEFINES_SVH
`define OPEN_SHARE_STATE_TABLE_DEFINES_SVH
// implication checked on every clock edge outside reset
`define OSST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define OSST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[design/osst_pkg.sv]
// Package for the open share state table: payload structs, codes, constants.
// No dependencies.
package osst_pkg;
  localparam int unsigned EntriesDef = 64;

  localparam logic [2:0] FN_OPEN = 3'd0;
  localparam logic [2:0] FN_CLOSE = 3'd1;
  localparam logic [2:0] FN_DOWN = 3'd2;
  localparam logic [2:0] FN_FIND = 3'd3;
  localparam logic [2:0] FN_HAS = 3'd4;
  localparam logic [2:0] FN_CLALL = 3'd5;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_INVAL = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_DENIED = 3'd3;
  localparam logic [2:0] ST_BAD = 3'd4;
  localparam logic [2:0] ST_OLD = 3'd5;

  localparam logic CFG_SERVER = 1'b0;
  localparam logic CFG_SEED = 1'b1;

  typedef struct packed {
    logic [2:0]  func;
    logic [63:0] client;
    logic [63:0] file;
    logic [1:0]  access_mask;
    logic [1:0]  deny_mask;
    logic [31:0] req_seqid;
    logic [31:0] req_server;
    logic [63:0] req_counter;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] res_seqid;
    logic [31:0] res_server;
    logic [63:0] res_counter;
    logic [63:0] res_client;
    logic [63:0] res_file;
    logic [1:0]  res_access;
    logic [1:0]  res_deny;
    logic        file_is_open;
    logic [6:0]  closed_count;
  } out_t;

  // one table row as stored in RAM (valid bits live in flops)
  typedef struct packed {
    logic [63:0] counter;
    logic [31:0] seqid;
    logic [63:0] client;
    logic [63:0] file;
    logic [1:0]  access;
    logic [1:0]  deny;
  } row_t;

  localparam int unsigned RowW = $bits(row_t);

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request word
    logic clr_scan;  // clear scan flags
    logic scan;      // rd data valid for current scan index
    logic finish;    // build result
    logic commit;    // apply table update
  } cmd_t;
endpackage

[design/open_share_state_table.sv]
// Top level of the open share state table: controller plus datapath.
// Depends on osst_pkg, osst_ctrl, osst_dp.
//
// channel  | direction | handshake             | payload
// in       | input     | in_valid_i/in_stall_o   | in_data_i (osst_pkg::in_t)
// out      | output    | out_valid_o/out_stall_i | out_data_o (osst_pkg::out_t)
// cfg      | input     | cfg_we_i              | cfg_idx_i, cfg_data_i
//
// Every operation reads all rows through the single RAM read port, one a cycle,
// and the result word is registered once the scan is done.
// Reset clears valid bits, server id and sets the counter to 1; no clear pass.
// The block takes one word at a time; a stalled result holds input off.
module open_share_state_table #(
  parameter int unsigned Entries = osst_pkg::EntriesDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  osst_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output osst_pkg::out_t out_data_o,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic [63:0]    cfg_data_i
);
  localparam int unsigned AW = (Entries > 1) ? $clog2(Entries) : 1;
  osst_pkg::cmd_t cmd;
  logic [AW-1:0] raddr;

  osst_ctrl #(.Entries(Entries)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .raddr_o(raddr), .cmd_o(cmd)
  );

  osst_dp #(.Entries(Entries)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .raddr_i(raddr), .in_data_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .out_data_o
  );
endmodule

[design/osst_ram.sv]
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module osst_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[design/osst_ctrl.sv]
// Controller for the open share state table: sequences the table scan.
// Depends on osst_pkg.
module osst_ctrl #(
  parameter int unsigned Entries = osst_pkg::EntriesDef,
  localparam int unsigned AW = (Entries > 1) ? $clog2(Entries) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [AW-1:0] raddr_o,
  output osst_pkg::cmd_t cmd_o
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;
  localparam logic [1:0] S_OUT = 2'd3;
  localparam logic [AW-1:0] LastIdx = AW'(Entries - 1);

  logic [1:0] state_q, state_d;
  logic [AW-1:0] idx_q, idx_d;
  logic rdv_q, rdv_d;  // RAM read data holds a row to scan (row idx_q - 1 while in S_SCAN)

  assign raddr_o = idx_q;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    rdv_d = 1'b0;
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cmd_o.clr_scan = 1'b1;
          idx_d = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = rdv_q;
        if (idx_q == LastIdx && rdv_q && Entries == 1) begin
          state_d = S_DONE;
        end else if (idx_q == LastIdx) begin
          rdv_d = 1'b1;
          state_d = S_DONE;
        end else begin
          idx_d = idx_q + AW'(1);
          rdv_d = 1'b1;
        end
      end
      S_DONE: begin
        // last row arrives here when rdv_q is set
        cmd_o.scan = rdv_q;
        if (!rdv_q) begin
          cmd_o.finish = 1'b1;
          cmd_o.commit = 1'b1;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q <= '0;
      rdv_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      rdv_q <= rdv_d;
    end
  end
endmodule

[design/osst_dp.sv]
// Datapath for the open share state table: row RAM, valid flops, scan logic.
// Depends on osst_pkg and osst_ram.
module osst_dp #(
  parameter int unsigned Entries = osst_pkg::EntriesDef,
  localparam int unsigned AW = (Entries > 1) ? $clog2(Entries) : 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  osst_pkg::cmd_t cmd_i,
  input  logic [AW-1:0]  raddr_i,
  input  osst_pkg::in_t  in_data_i,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic [63:0]    cfg_data_i,
  output osst_pkg::out_t out_data_o
);
  osst_pkg::in_t req_q;
  osst_pkg::row_t rd_row, wr_row;
  logic [Entries-1:0] valid_q;
  logic [31:0] server_q;
  logic [63:0] next_ctr_q;
  logic [AW-1:0] sidx_q;       // index of row on rd_row
  logic free_hit_q, match_hit_q, conflict_q, file_hit_q;
  logic [AW-1:0] free_idx_q, match_idx_q;
  osst_pkg::row_t match_row_q;
  logic [Entries-1:0] kill_q;  // rows closed by close-all
  logic [6:0] cnt_q;
  logic we;
  logic [AW-1:0] waddr;
  osst_pkg::out_t out_d;

  osst_ram #(.Width(osst_pkg::RowW), .Depth(Entries)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wr_row),
    .raddr_i(raddr_i),
    .rdata_o(rd_row)
  );

  // per-row compares of the scan
  logic row_v, same_file, same_client, ctr_hit, conf;
  assign row_v = valid_q[sidx_q];
  assign same_file = rd_row.file == req_q.file;
  assign same_client = rd_row.client == req_q.client;
  assign ctr_hit = rd_row.counter == req_q.req_counter;
  assign conf = ((req_q.access_mask & rd_row.deny) != 2'b00)
             || ((rd_row.access & req_q.deny_mask) != 2'b00);

  // result and update decisions
  logic [2:0] fn;
  logic [2:0] st;
  logic owned_ok;
  logic [31:0] seq_inc;
  assign fn = req_q.func;
  assign seq_inc = match_row_q.seqid + 32'd1;

  always_comb begin
    st = osst_pkg::ST_OK;
    owned_ok = 1'b0;
    we = 1'b0;
    waddr = match_idx_q;
    wr_row = match_row_q;
    case (fn)
      osst_pkg::FN_OPEN: begin
        waddr = free_idx_q;
        wr_row.counter = next_ctr_q;
        wr_row.seqid = 32'd1;
        wr_row.client = req_q.client;
        wr_row.file = req_q.file;
        wr_row.access = req_q.access_mask;
        wr_row.deny = req_q.deny_mask;
        if (req_q.access_mask == 2'b00) st = osst_pkg::ST_INVAL;
        else if (!free_hit_q) st = osst_pkg::ST_FULL;
        else if (conflict_q) st = osst_pkg::ST_DENIED;
        else we = 1'b1;
      end
      osst_pkg::FN_CLOSE, osst_pkg::FN_DOWN: begin
        if (!match_hit_q || match_row_q.client != req_q.client) st = osst_pkg::ST_BAD;
        else if (req_q.req_seqid < match_row_q.seqid) st = osst_pkg::ST_OLD;
        else if (req_q.req_seqid != match_row_q.seqid) st = osst_pkg::ST_BAD;
        else if (fn == osst_pkg::FN_DOWN
                 && (req_q.access_mask & ~match_row_q.access) != 2'b00) begin
          st = osst_pkg::ST_INVAL;
        end else owned_ok = 1'b1;
        wr_row.seqid = seq_inc;
        wr_row.access = req_q.access_mask;
        wr_row.deny = req_q.deny_mask;
        we = owned_ok && fn == osst_pkg::FN_DOWN;
      end
      osst_pkg::FN_FIND: begin
        if (!match_hit_q) st = osst_pkg::ST_BAD;
      end
      osst_pkg::FN_HAS, osst_pkg::FN_CLALL: st = osst_pkg::ST_OK;
      default: st = osst_pkg::ST_INVAL;
    endcase
    we = we && cmd_i.commit;
  end

  // result word, all undefined fields zero
  always_comb begin
    out_d = '0;
    out_d.status = st;
    if (st == osst_pkg::ST_OK) begin
      case (fn)
        osst_pkg::FN_OPEN: begin
          out_d.res_seqid = 32'd1;
          out_d.res_server = server_q;
          out_d.res_counter = next_ctr_q;
        end
        osst_pkg::FN_CLOSE, osst_pkg::FN_DOWN: begin
          out_d.res_seqid = seq_inc;
          out_d.res_server = server_q;
          out_d.res_counter = match_row_q.counter;
        end
        osst_pkg::FN_FIND: begin
          out_d.res_seqid = match_row_q.seqid;
          out_d.res_server = server_q;
          out_d.res_counter = match_row_q.counter;
          out_d.res_client = match_row_q.client;
          out_d.res_file = match_row_q.file;
          out_d.res_access = match_row_q.access;
          out_d.res_deny = match_row_q.deny;
        end
        osst_pkg::FN_HAS: out_d.file_is_open = file_hit_q;
        osst_pkg::FN_CLALL: out_d.closed_count = cnt_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      server_q <= '0;
      next_ctr_q <= 64'd1;
    end else begin
      if (cfg_we_i && cfg_idx_i == osst_pkg::CFG_SERVER) server_q <= cfg_data_i[31:0];
      if (cfg_we_i && cfg_idx_i == osst_pkg::CFG_SEED) next_ctr_q <= cfg_data_i;
      if (cmd_i.commit) begin
        case (fn)
          osst_pkg::FN_OPEN: begin
            if (req_q.access_mask != 2'b00 && free_hit_q) begin
              next_ctr_q <= next_ctr_q + 64'd1;
              if (!conflict_q) valid_q[free_idx_q] <= 1'b1;
            end
          end
          osst_pkg::FN_CLOSE: if (owned_ok) valid_q[match_idx_q] <= 1'b0;
          osst_pkg::FN_CLALL: valid_q <= valid_q & ~kill_q;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= in_data_i;
    if (cmd_i.clr_scan) begin
      sidx_q <= '0;
      free_hit_q <= 1'b0;
      match_hit_q <= 1'b0;
      conflict_q <= 1'b0;
      file_hit_q <= 1'b0;
      kill_q <= '0;
      cnt_q <= '0;
      free_idx_q <= '0;
      match_idx_q <= '0;
    end
    if (cmd_i.scan) begin
      sidx_q <= sidx_q + AW'(1);
      if (!row_v && !free_hit_q) begin
        free_hit_q <= 1'b1;
        free_idx_q <= sidx_q;
      end
      if (row_v && ctr_hit && !match_hit_q && req_q.req_server == server_q) begin
        match_hit_q <= 1'b1;
        match_idx_q <= sidx_q;
        match_row_q <= rd_row;
      end
      if (row_v && same_file) begin
        file_hit_q <= 1'b1;
        if (conf) conflict_q <= 1'b1;
      end
      if (row_v && same_client) begin
        kill_q[sidx_q] <= 1'b1;
        if (cnt_q != 7'd127) cnt_q <= cnt_q + 7'd1;
      end
    end
    if (cmd_i.finish) out_data_o <= out_d;
  end
endmodule

[design/osst_checker.sv]
// Port checker for the open share state table, bound to the top level.
// Depends on osst_pkg and open_share_state_table_defines.svh.
`include "open_share_state_table_defines.svh"
module osst_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input osst_pkg::out_t out_data_o
);
  `OSST_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `OSST_ASSERT_IMP(a_no_take_while_out, clk_i, rst_ni, out_valid_o, in_stall_o)
  `OSST_ASSERT_NEXT(a_out_holds, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_data_o))
  `OSST_ASSERT_IMP(a_status_range, clk_i, rst_ni, out_valid_o,
                   out_data_o.status <= osst_pkg::ST_OLD)
endmodule

bind open_share_state_table osst_checker u_osst_checker (.*);
